[rtl/core/rrsc_pkg.sv]
// Package: shared widths, defaults and controller/datapath handshake structs for the rank counter.
`timescale 1ns / 1ps
package rrsc_pkg;

  // Fixed field widths of the channel payloads
  localparam int SAMPLE_W = 10;
  localparam int RANK_W   = 11;

  // Parameter defaults
  localparam int VALUE_BITS_DEF = 10;
  localparam int MAX_ITEMS_DEF  = 1024;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;   // capture the sample beat and clear the walk registers
    logic rd;     // read the next node on the path
    logic clr;    // write zero at the clearing pointer and advance it
    logic emit;   // load the result register and count the item unless it overflowed
  } rrsc_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic full;      // capacity reached
    logic clr_last;  // clearing pointer at the last node
    logic out_free;  // result register can take a beat this cycle
  } rrsc_sts_t;

endpackage

[rtl/core/rrsc_if.sv]
// Interfaces: sample channel and result channel with valid/ready handshake.
`timescale 1ns / 1ps
interface rrsc_in_if;
  logic                          valid;
  logic                          ready;
  logic [rrsc_pkg::SAMPLE_W-1:0] sample_value;

  modport source (output valid, output sample_value, input ready);
  modport sink   (input valid, input sample_value, output ready);
endinterface

interface rrsc_out_if;
  logic                        valid;
  logic                        ready;
  logic [rrsc_pkg::RANK_W-1:0] running_rank;
  logic                        overflow;

  modport source (output valid, output running_rank, output overflow, input ready);
  modport sink   (input valid, input running_rank, input overflow, output ready);
endinterface

[rtl/core/rrsc_ctrl.sv]
// Controller: clearing pass, tree walk sequencing and result hand-off.
`timescale 1ns / 1ps
module rrsc_ctrl #(
  parameter int VALUE_BITS = rrsc_pkg::VALUE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rrsc_pkg::rrsc_sts_t sts,
  output rrsc_pkg::rrsc_cmd_t cmd
);
  import rrsc_pkg::*;

  localparam int LVL_W = $clog2(VALUE_BITS + 1);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_WALK  = 4'b0100,
    ST_DRAIN = 4'b1000
  } state_t;

  state_t             state_r, state_nxt;
  logic [LVL_W-1:0]   lvl_r, lvl_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    lvl_nxt   = lvl_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          lvl_nxt  = '0;
          // a full counter skips the walk and reports overflow
          state_nxt = sts.full ? ST_DRAIN : ST_WALK;
        end
      end
      ST_WALK: begin
        cmd.rd  = 1'b1;
        lvl_nxt = lvl_r + LVL_W'(1);
        if (lvl_r == LVL_W'(VALUE_BITS)) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      lvl_r   <= '0;
    end else begin
      state_r <= state_nxt;
      lvl_r   <= lvl_nxt;
    end
  end

endmodule

[rtl/core/rrsc_dp.sv]
// Datapath: tally memory, path walk, rank accumulator, item counter and result register.
`timescale 1ns / 1ps
module rrsc_dp #(
  parameter int VALUE_BITS = rrsc_pkg::VALUE_BITS_DEF,
  parameter int MAX_ITEMS  = rrsc_pkg::MAX_ITEMS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rrsc_pkg::rrsc_cmd_t           cmd,
  output rrsc_pkg::rrsc_sts_t           sts,
  input  logic [rrsc_pkg::SAMPLE_W-1:0] sample_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rrsc_pkg::RANK_W-1:0]   running_rank,
  output logic                          overflow
);
  import rrsc_pkg::*;

  localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
  localparam int ADDR_W = VALUE_BITS + 1;
  localparam int DEPTH  = 2 ** ADDR_W;
  localparam int EXT_W  = (CNT_W + 1 > RANK_W) ? CNT_W + 1 : RANK_W;

  // Tally memory, heap order with the root at node one
  logic [CNT_W-1:0] tree_mem [DEPTH];

  logic [VALUE_BITS-1:0] v_sh_r;
  logic [ADDR_W-1:0]     node_r;
  logic [ADDR_W-1:0]     addr_q_r;
  logic                  dir_q_r;
  logic                  rvalid_r;
  logic [CNT_W-1:0]      rdata_r;
  logic [CNT_W-1:0]      prev_r;
  logic                  prev_dir_r;
  logic                  have_prev_r;
  logic [CNT_W-1:0]      greater_r, greater_nxt;
  logic                  ovf_r;
  logic [CNT_W-1:0]      items_seen_r;
  logic [ADDR_W-1:0]     clr_addr_r;
  logic                  out_valid_r;
  logic [RANK_W-1:0]     running_rank_r;
  logic                  overflow_r;

  logic                  mem_we;
  logic [ADDR_W-1:0]     mem_wa;
  logic [CNT_W-1:0]      mem_wd;
  logic [EXT_W-1:0]      rank_ext;

  // Memory port: single write, registered read
  always_comb begin
    mem_we = cmd.clr | rvalid_r;
    mem_wa = cmd.clr ? clr_addr_r : addr_q_r;
    mem_wd = cmd.clr ? '0 : rdata_r + CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (mem_we) tree_mem[mem_wa] <= mem_wd;
    if (cmd.rd) rdata_r <= tree_mem[node_r];
  end

  // A left turn leaves the right sibling's tally (parent minus child) as larger values
  always_comb begin
    greater_nxt = greater_r;
    if (rvalid_r && have_prev_r && !prev_dir_r)
      greater_nxt = greater_r + (prev_r - rdata_r);
    rank_ext = EXT_W'(greater_nxt) + EXT_W'(1);
  end

  // Path walk registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      v_sh_r      <= VALUE_BITS'(sample_value);
      node_r      <= ADDR_W'(1);
      greater_r   <= '0;
      have_prev_r <= 1'b0;
      ovf_r       <= sts.full;
    end else begin
      if (cmd.rd) begin
        addr_q_r <= node_r;
        dir_q_r  <= v_sh_r[VALUE_BITS-1];
        node_r   <= {node_r[ADDR_W-2:0], v_sh_r[VALUE_BITS-1]};
        v_sh_r   <= v_sh_r << 1;
      end
      if (rvalid_r) begin
        greater_r   <= greater_nxt;
        prev_r      <= rdata_r;
        prev_dir_r  <= dir_q_r;
        have_prev_r <= 1'b1;
      end
    end
  end

  // Control state: read pipeline flag, item counter, clearing pointer, result beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rvalid_r     <= 1'b0;
      items_seen_r <= '0;
      clr_addr_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      rvalid_r <= cmd.rd;
      if (cmd.clr) clr_addr_r <= clr_addr_r + ADDR_W'(1);
      if (cmd.emit && !ovf_r) items_seen_r <= items_seen_r + CNT_W'(1);
      if (cmd.emit) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      running_rank_r <= ovf_r ? '0 : rank_ext[RANK_W-1:0];
      overflow_r     <= ovf_r;
    end
  end

  always_comb begin
    sts.full     = (items_seen_r >= CNT_W'(MAX_ITEMS));
    sts.clr_last = &clr_addr_r;
    sts.out_free = !out_valid_r || out_ready;
  end

  assign out_valid    = out_valid_r;
  assign running_rank = running_rank_r;
  assign overflow     = overflow_r;

endmodule

[rtl/core/running_rank_segment_counter_unit.sv]
// Top level: running rank counter over a segment tree of value tallies.
//
// Channels: in_ch carries one sample_value per beat; out_ch returns one beat
// per sample with running_rank (one plus the number of earlier samples that
// are strictly larger) and overflow. Both use valid/ready; a beat moves on a
// rising edge with valid and ready high.
// Timing: a sample walks the tree from root to leaf, one node read-modify-write
// per cycle on the single tally memory port, VALUE_BITS+1 levels. The next
// sample is taken only after the result is loaded into the output register;
// out_ch.valid rises when that register is loaded at the end of the walk.
// Once MAX_ITEMS samples have been counted, later samples skip the walk and
// return rank zero with overflow set, and the tree is left untouched.
// Reset: rst_n clears the item count and starts a clearing pass that zeroes
// all 2^(VALUE_BITS+1) tally nodes, one per cycle; in_ch.ready stays low until
// it completes.
// Back-pressure: the result sits in an output register, so the next sample is
// taken while it waits; a second result is held inside until out_ch.ready.
`timescale 1ns / 1ps
module running_rank_segment_counter_unit #(
  parameter int VALUE_BITS = rrsc_pkg::VALUE_BITS_DEF,
  parameter int MAX_ITEMS  = rrsc_pkg::MAX_ITEMS_DEF
) (
  input logic         clk,
  input logic         rst_n,
  rrsc_in_if.sink     in_ch,
  rrsc_out_if.source  out_ch
);
  import rrsc_pkg::*;

  rrsc_cmd_t cmd;
  rrsc_sts_t sts;

  rrsc_ctrl #(
    .VALUE_BITS (VALUE_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rrsc_dp #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_ITEMS  (MAX_ITEMS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .sample_value (in_ch.sample_value),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .running_rank (out_ch.running_rank),
    .overflow     (out_ch.overflow)
  );

endmodule
